### design/pmcd_pkg.sv
// ----------------------------------------------------------------------------
// pmcd_pkg
// Shared widths, register indexes and types of the patch mean change detector.
// ----------------------------------------------------------------------------
package pmcd_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int SUM_W      = 17;
    localparam int LIM_W      = 17;
    localparam int DIM_W      = 11;
    localparam int PS_W       = 5;
    localparam int TH_W       = 8;
    localparam int PREM_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DAT_W  = 11;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIZE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_THRESHOLD = 2'd3;

    // per-pixel control that rides along the pipeline
    typedef struct packed {
        logic win;       // median window centered on a real pixel
        logic first;     // first pixel of a patch
        logic last;      // last pixel of a patch
        logic col_zero;  // column 0: window refills with replicated column
        logic top_sel;   // row >= 2: top line store entry is valid
    } t_flags;

    typedef struct packed {
        logic [ROW_W-1:0] patch_row;
        logic [COL_W-1:0] patch_col;
        logic             foreground;
    } t_result;

endpackage

### design/pmcd_if.sv
// ----------------------------------------------------------------------------
// pmcd_if
// Valid/ready channels of the patch mean change detector.
// ----------------------------------------------------------------------------
interface pmcd_pix_if;
    logic                     valid;
    logic                     ready;
    logic [pmcd_pkg::PIX_W-1:0] cur_pixel;
    logic [pmcd_pkg::PIX_W-1:0] ref_pixel;
    logic                     frame_start;
    modport source (output valid, cur_pixel, ref_pixel, frame_start, input ready);
    modport sink   (input valid, cur_pixel, ref_pixel, frame_start, output ready);
endinterface

interface pmcd_res_if;
    logic                     valid;
    logic                     ready;
    logic [pmcd_pkg::ROW_W-1:0] patch_row;
    logic [pmcd_pkg::COL_W-1:0] patch_col;
    logic                     foreground;
    modport source (output valid, patch_row, patch_col, foreground, input ready);
    modport sink   (input valid, patch_row, patch_col, foreground, output ready);
endinterface

interface pmcd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pmcd_pkg::CFG_IDX_W-1:0] reg_index;
    logic [pmcd_pkg::CFG_DAT_W-1:0] reg_data;
    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

### design/pmcd_div.sv
// ----------------------------------------------------------------------------
// pmcd_div
// Serial restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module pmcd_div #(
    parameter int DW = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_num,
    input  logic [pmcd_pkg::PS_W-1:0]   i_den,
    output logic                        o_done,
    output logic [DW-1:0]               o_quot,
    output logic [pmcd_pkg::PREM_W-1:0] o_rem
);
    import pmcd_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_num;
    logic [DW-1:0]    r_quot;
    logic [PREM_W-1:0] r_rem;
    logic [PS_W-1:0]  trial;
    logic [PS_W-1:0]  diff;
    logic             ge;
    logic [PREM_W-1:0] n_rem;

    // divisor is read live: it settles before the first step
    always_comb begin
        trial = {r_rem, r_num[DW-1]};
        diff  = trial - i_den;
        ge    = trial >= i_den;
        n_rem = ge ? diff[PREM_W-1:0] : trial[PREM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_quot <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DW-2:0], 1'b0};
            r_quot <= {r_quot[DW-2:0], ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### design/pmcd_pos.sv
// ----------------------------------------------------------------------------
// pmcd_pos
// Raster position tracking, patch quotient/remainder counters and line store
// addressing. Counters are re-derived by a serial divide after a config write.
// ----------------------------------------------------------------------------
module pmcd_pos #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int CW = $clog2(MAX_WIDTH + 1),
    parameter int YW = $clog2(MAX_HEIGHT),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int AW = $clog2(2 * MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic                       i_frame_start,
    input  logic [CW-1:0]              i_w,
    input  logic [HW-1:0]              i_h,
    input  logic [pmcd_pkg::PS_W-1:0]  i_p,
    input  logic                       i_recalc,
    output logic                       o_busy,
    output pmcd_pkg::t_flags           o_flags,
    output logic [XW-1:0]              o_pc,
    output logic [pmcd_pkg::ROW_W-1:0] o_row,
    output logic [AW-1:0]              o_wr_addr,
    output logic [AW-1:0]              o_mid_addr
);
    import pmcd_pkg::*;

    localparam int DW = (XW > YW) ? XW : YW;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIVX = 2'd1;
    localparam logic [1:0] ST_DIVY = 2'd2;

    logic [YW-1:0]     r_rpos;
    logic [CW-1:0]     r_cpos;
    logic [XW-1:0]     r_xq, n_xq;
    logic [PREM_W-1:0] r_xr, n_xr;
    logic [YW-1:0]     r_yq, n_yq;
    logic [PREM_W-1:0] r_yr, n_yr;
    logic [1:0]        r_state;

    logic [CW-1:0]     c0, c;
    logic [YW-1:0]     rr0, r;
    logic [YW:0]       r1;
    logic              wrap;
    logic [XW-1:0]     cx;
    logic [PS_W-1:0]   xr_inc, yr_inc;

    logic              div_start, div_done;
    logic [DW-1:0]     div_num, div_quot, x_last, y_last;
    logic [PREM_W-1:0] div_rem;

    always_comb begin
        c0   = i_frame_start ? '0 : r_cpos;
        rr0  = i_frame_start ? '0 : r_rpos;
        wrap = c0 >= i_w;
        c    = wrap ? '0 : c0;
        r1   = {1'b0, rr0} + (YW+1)'(wrap);
        r    = (r1 >= (YW+1)'(i_h)) ? '0 : r1[YW-1:0];
        cx   = c[XW-1:0];
    end

    assign xr_inc = {1'b0, r_xr} + PS_W'(1);
    assign yr_inc = {1'b0, r_yr} + PS_W'(1);

    always_comb begin
        n_xq = r_xq;
        n_xr = r_xr;
        n_yq = r_yq;
        n_yr = r_yr;
        if (c == CW'(1)) begin
            n_xq = '0;
            n_xr = '0;
        end else if (c != '0) begin
            if (xr_inc == i_p) begin
                n_xq = r_xq + XW'(1);
                n_xr = '0;
            end else begin
                n_xr = xr_inc[PREM_W-1:0];
            end
        end
        // rows only change at column 0
        if (c == '0) begin
            if (r <= YW'(1)) begin
                n_yq = '0;
                n_yr = '0;
            end else if (yr_inc == i_p) begin
                n_yq = r_yq + YW'(1);
                n_yr = '0;
            end else begin
                n_yr = yr_inc[PREM_W-1:0];
            end
        end
    end

    always_comb begin
        o_flags.win      = (r != '0) && (c != '0);
        o_flags.first    = (n_yr == '0) && (n_xr == '0);
        o_flags.last     = (({1'b0, n_yr} + PS_W'(1)) == i_p) &&
                           (({1'b0, n_xr} + PS_W'(1)) == i_p);
        o_flags.col_zero = (c == '0);
        o_flags.top_sel  = r >= YW'(2);
        o_pc             = n_xq;
        o_row            = ROW_W'(n_yq);
        o_wr_addr        = AW'(cx) + (r[0] ? AW'(MAX_WIDTH) : AW'(0));
        o_mid_addr       = AW'(cx) + (r[0] ? AW'(0) : AW'(MAX_WIDTH));
    end

    // divide the window center of the last pixel again with the new patch size
    always_comb begin
        x_last    = (r_cpos >= CW'(2)) ? DW'(r_cpos - CW'(2)) : '0;
        y_last    = (r_rpos != '0) ? DW'(r_rpos - YW'(1)) : '0;
        div_start = ((r_state == ST_IDLE) && i_recalc) ||
                    ((r_state == ST_DIVX) && div_done);
        div_num   = (r_state == ST_IDLE) ? x_last : y_last;
    end

    pmcd_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (i_p),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpos  <= '0;
            r_cpos  <= '0;
            r_xq    <= '0;
            r_xr    <= '0;
            r_yq    <= '0;
            r_yr    <= '0;
            r_state <= ST_IDLE;
        end else begin
            if (i_acc) begin
                r_rpos <= r;
                r_cpos <= c + CW'(1);
                r_xq   <= n_xq;
                r_xr   <= n_xr;
                r_yq   <= n_yq;
                r_yr   <= n_yr;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_recalc) r_state <= ST_DIVX;
                end
                ST_DIVX: begin
                    if (div_done) begin
                        r_xq    <= div_quot[XW-1:0];
                        r_xr    <= div_rem;
                        r_state <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (div_done) begin
                        r_yq    <= div_quot[YW-1:0];
                        r_yr    <= div_rem;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = r_state != ST_IDLE;

endmodule

### design/pmcd_median.sv
// ----------------------------------------------------------------------------
// pmcd_median
// Two-line store and 3x3 median for one pixel stream. The window keeps its
// columns sorted, so the median is med3(max of lows, med of mids, min of highs).
// ----------------------------------------------------------------------------
module pmcd_median #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW = $clog2(2 * MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_acc,
    input  logic [pmcd_pkg::PIX_W-1:0] i_pix,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [AW-1:0]              i_mid_addr,
    input  logic                       i_s1_vld,
    input  logic                       i_s1_col_zero,
    input  logic                       i_s1_top_sel,
    input  logic                       i_s2_vld,
    output logic [pmcd_pkg::PIX_W-1:0] o_med
);
    import pmcd_pkg::*;

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, b, c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [PIX_W-1:0] mem [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0] r_mid, r_top, r_pix;
    logic [PIX_W-1:0] r_lo [0:2];
    logic [PIX_W-1:0] r_md [0:2];
    logic [PIX_W-1:0] r_hi [0:2];
    logic [PIX_W-1:0] r_med;
    logic [PIX_W-1:0] top, s_lo, s_md, s_hi;

    // top write address equals the write address; read returns the old row
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            mem[i_wr_addr] <= i_pix;
            r_mid          <= mem[i_mid_addr];
            r_top          <= mem[i_wr_addr];
            r_pix          <= i_pix;
        end
    end

    always_comb begin
        top  = i_s1_top_sel ? r_top : r_mid;
        s_lo = min2(min2(top, r_mid), r_pix);
        s_hi = max2(max2(top, r_mid), r_pix);
        s_md = med3(top, r_mid, r_pix);
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_vld) begin
            if (i_s1_col_zero) begin
                for (int k = 0; k < 3; k++) begin
                    r_lo[k] <= s_lo;
                    r_md[k] <= s_md;
                    r_hi[k] <= s_hi;
                end
            end else begin
                for (int k = 0; k < 2; k++) begin
                    r_lo[k] <= r_lo[k+1];
                    r_md[k] <= r_md[k+1];
                    r_hi[k] <= r_hi[k+1];
                end
                r_lo[2] <= s_lo;
                r_md[2] <= s_md;
                r_hi[2] <= s_hi;
            end
        end
        if (i_s2_vld) begin
            r_med <= med3(max2(max2(r_lo[0], r_lo[1]), r_lo[2]),
                          med3(r_md[0], r_md[1], r_md[2]),
                          min2(min2(r_hi[0], r_hi[1]), r_hi[2]));
        end
    end

    assign o_med = r_med;

endmodule

### design/pmcd_patch.sv
// ----------------------------------------------------------------------------
// pmcd_patch
// Per patch column sums of both streams, read-modify-write with a one-deep
// bypass, and the threshold test on the finished patch.
// ----------------------------------------------------------------------------
module pmcd_patch #(
    parameter int MAX_WIDTH = 1024,
    parameter int XW = $clog2(MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s2_vld,
    input  logic [XW-1:0]              i_s2_pc,
    input  logic                       i_s3_vld,
    input  pmcd_pkg::t_flags           i_s3_flags,
    input  logic [XW-1:0]              i_s3_pc,
    input  logic [pmcd_pkg::ROW_W-1:0] i_s3_row,
    input  logic [pmcd_pkg::PIX_W-1:0] i_med_a,
    input  logic [pmcd_pkg::PIX_W-1:0] i_med_b,
    input  logic [pmcd_pkg::LIM_W-1:0] i_lim,
    output logic                       o_push,
    output pmcd_pkg::t_result          o_res
);
    import pmcd_pkg::*;

    logic [2*SUM_W-1:0] mem [0:MAX_WIDTH-1];
    logic [2*SUM_W-1:0] r_rd;
    logic               r_fwd;
    logic [2*SUM_W-1:0] r_fwd_d;
    logic [2*SUM_W-1:0] base;
    logic [SUM_W-1:0]   sum_a, sum_b;
    logic               wr_en;
    logic               r_s4_vld;
    logic [SUM_W-1:0]   r_sa, r_sb, diff;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;

    always_comb begin
        base  = r_fwd ? r_fwd_d : r_rd;
        wr_en = i_s3_vld && i_s3_flags.win;
        if (i_s3_flags.first) begin
            sum_a = SUM_W'(i_med_a);
            sum_b = SUM_W'(i_med_b);
        end else begin
            sum_a = base[2*SUM_W-1:SUM_W] + SUM_W'(i_med_a);
            sum_b = base[SUM_W-1:0] + SUM_W'(i_med_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s2_vld) r_rd <= mem[i_s2_pc];
        if (wr_en) mem[i_s3_pc] <= {sum_a, sum_b};
        // the read issued this edge misses the write of this edge
        r_fwd   <= wr_en && (i_s2_pc == i_s3_pc);
        r_fwd_d <= {sum_a, sum_b};
        r_sa    <= sum_a;
        r_sb    <= sum_b;
        r_row   <= i_s3_row;
        r_col   <= COL_W'(i_s3_pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= wr_en && i_s3_flags.last;
        end
    end

    assign diff = (r_sa > r_sb) ? (r_sa - r_sb) : (r_sb - r_sa);

    always_comb begin
        o_push           = r_s4_vld;
        o_res.patch_row  = r_row;
        o_res.patch_col  = r_col;
        o_res.foreground = diff >= i_lim;
    end

endmodule

### design/pmcd_fifo.sv
// ----------------------------------------------------------------------------
// pmcd_fifo
// Result queue on the output channel.
// ----------------------------------------------------------------------------
module pmcd_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  pmcd_pkg::t_result               i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output pmcd_pkg::t_result               o_data,
    output logic [pmcd_pkg::FIFO_CNT_W-1:0] o_cnt
);
    import pmcd_pkg::*;

    t_result               r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  pop;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + FIFO_PTR_W'(1);
            if (pop)    r_rd <= r_rd + FIFO_PTR_W'(1);
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data = r_mem[r_rd];
    assign o_cnt  = r_cnt;

endmodule

### design/patch_mean_change_detector.sv
// ----------------------------------------------------------------------------
// patch_mean_change_detector
// 3x3 median on current and reference frames, patch sums, foreground test.
// ----------------------------------------------------------------------------
// Takes one current/reference pixel pair per clock in raster order while input
// is not stalled, and gives one result per patch whose edges lie inside the
// frame through an 8-entry output queue. Input stalls when the queue plus the
// four pipeline stages could fill and while a configuration write is offered.
// Each configuration write then holds off input while a serial divider
// re-derives the patch position counters from the held raster position. Line
// stores hold two rows of each stream in block memory; patch sums live in a
// MAX_WIDTH-entry memory.
// ----------------------------------------------------------------------------
module patch_mean_change_detector #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pmcd_pix_if.sink i_pix,
    pmcd_cfg_if.sink i_cfg,
    pmcd_res_if.source o_res
);
    import pmcd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(2 * MAX_WIDTH);

    logic [DIM_W-1:0] r_fw, r_fh;
    logic [PS_W-1:0]  r_ps;
    logic [TH_W-1:0]  r_th;
    logic [CW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [PS_W-1:0]  p_eff;
    logic [9:0]       psq;
    logic [8:0]       r_psq;
    logic [17:0]      lim_full;
    logic [LIM_W-1:0] r_lim;

    logic             cfg_wr, acc, busy;
    logic [FIFO_CNT_W-1:0] fifo_cnt, inflight;

    t_flags           pos_flags;
    logic [XW-1:0]    pos_pc;
    logic [ROW_W-1:0] pos_row;
    logic [AW-1:0]    wr_addr, mid_addr;

    logic             r_s1_vld, r_s2_vld, r_s3_vld;
    t_flags           r_s1_flags, r_s2_flags, r_s3_flags;
    logic [XW-1:0]    r_s1_pc, r_s2_pc, r_s3_pc;
    logic [ROW_W-1:0] r_s1_row, r_s2_row, r_s3_row;

    logic [PIX_W-1:0] med_a, med_b;
    logic             push;
    t_result          res_in, res_out;

    // configuration
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= DIM_W'(640);
            r_fh <= DIM_W'(480);
            r_ps <= PS_W'(5);
            r_th <= TH_W'(50);
        end else if (cfg_wr) begin
            case (i_cfg.reg_index)
                REG_FRAME_WIDTH:    r_fw <= i_cfg.reg_data;
                REG_FRAME_HEIGHT:   r_fh <= i_cfg.reg_data;
                REG_PATCH_SIZE:     r_ps <= i_cfg.reg_data[PS_W-1:0];
                REG_MEAN_THRESHOLD: r_th <= i_cfg.reg_data[TH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = (r_fw < 4) ? CW'(4) : ((r_fw > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(r_fw));
        h_eff = (r_fh < 4) ? HW'(4) : ((r_fh > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_fh));
        p_eff = (r_ps == '0) ? PS_W'(1) : ((r_ps > 16) ? PS_W'(16) : r_ps);
        psq      = p_eff * p_eff;
        lim_full = r_psq * ({1'b0, r_th} + 9'd1);
    end

    // p*p*(threshold+1), two registered multiplies
    always_ff @(posedge i_clk) begin
        r_psq <= psq[8:0];
        r_lim <= lim_full[LIM_W-1:0];
    end

    // input handshake: space for every request still in flight
    assign inflight = fifo_cnt + FIFO_CNT_W'(r_s1_vld) + FIFO_CNT_W'(r_s2_vld)
                    + FIFO_CNT_W'(r_s3_vld) + FIFO_CNT_W'(push);
    assign i_pix.ready = !busy && !i_cfg.valid && (inflight < FIFO_CNT_W'(FIFO_DEPTH));
    assign acc = i_pix.valid && i_pix.ready;

    pmcd_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_frame_start (i_pix.frame_start),
        .i_w           (w_eff),
        .i_h           (h_eff),
        .i_p           (p_eff),
        .i_recalc      (cfg_wr),
        .o_busy        (busy),
        .o_flags       (pos_flags),
        .o_pc          (pos_pc),
        .o_row         (pos_row),
        .o_wr_addr     (wr_addr),
        .o_mid_addr    (mid_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_flags <= pos_flags;
        r_s1_pc    <= pos_pc;
        r_s1_row   <= pos_row;
        r_s2_flags <= r_s1_flags;
        r_s2_pc    <= r_s1_pc;
        r_s2_row   <= r_s1_row;
        r_s3_flags <= r_s2_flags;
        r_s3_pc    <= r_s2_pc;
        r_s3_row   <= r_s2_row;
    end

    pmcd_median #(.MAX_WIDTH(MAX_WIDTH)) u_med_cur (
        .i_clk         (i_clk),
        .i_acc         (acc),
        .i_pix         (i_pix.cur_pixel),
        .i_wr_addr     (wr_addr),
        .i_mid_addr    (mid_addr),
        .i_s1_vld      (r_s1_vld),
        .i_s1_col_zero (r_s1_flags.col_zero),
        .i_s1_top_sel  (r_s1_flags.top_sel),
        .i_s2_vld      (r_s2_vld),
        .o_med         (med_a)
    );

    pmcd_median #(.MAX_WIDTH(MAX_WIDTH)) u_med_ref (
        .i_clk         (i_clk),
        .i_acc         (acc),
        .i_pix         (i_pix.ref_pixel),
        .i_wr_addr     (wr_addr),
        .i_mid_addr    (mid_addr),
        .i_s1_vld      (r_s1_vld),
        .i_s1_col_zero (r_s1_flags.col_zero),
        .i_s1_top_sel  (r_s1_flags.top_sel),
        .i_s2_vld      (r_s2_vld),
        .o_med         (med_b)
    );

    pmcd_patch #(.MAX_WIDTH(MAX_WIDTH)) u_patch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2_vld   (r_s2_vld),
        .i_s2_pc    (r_s2_pc),
        .i_s3_vld   (r_s3_vld),
        .i_s3_flags (r_s3_flags),
        .i_s3_pc    (r_s3_pc),
        .i_s3_row   (r_s3_row),
        .i_med_a    (med_a),
        .i_med_b    (med_b),
        .i_lim      (r_lim),
        .o_push     (push),
        .o_res      (res_in)
    );

    pmcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res_in),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (res_out),
        .o_cnt   (fifo_cnt)
    );

    assign o_res.patch_row  = res_out.patch_row;
    assign o_res.patch_col  = res_out.patch_col;
    assign o_res.foreground = res_out.foreground;

endmodule

### design/pmcd_checker.sv
// ----------------------------------------------------------------------------
// pmcd_checker
// Port-level checks of the patch mean change detector.
// ----------------------------------------------------------------------------
module pmcd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_cfg_valid,
    input logic                       i_cfg_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [pmcd_pkg::ROW_W-1:0] i_out_row,
    input logic [pmcd_pkg::COL_W-1:0] i_out_col,
    input logic                       i_out_fg
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_row) && $stable(i_out_col) && $stable(i_out_fg))
        else $error("result payload changed while stalled");

    a_cfg_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> !i_in_ready)
        else $error("pixel taken alongside a config write");

    a_cfg_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_in_ready)
        else $error("pixel taken while patch counters are recomputed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind patch_mean_change_detector pmcd_checker u_pmcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_row   (o_res.patch_row),
    .i_out_col   (o_res.patch_col),
    .i_out_fg    (o_res.foreground)
);
